@@ rtl/whp_pkg.sv @@
// shared types and constants for the wav header parser
// no dependencies
`default_nettype none

package whp_pkg;

  localparam logic [5:0] HDR_BYTES    = 6'd44;
  localparam logic [5:0] LAST_POS     = 6'd43;
  localparam logic [5:0] CHECK_POS    = 6'd35;
  localparam logic [7:0] FMT_LEN_BYTE = 8'd16;

  // tags packed little-endian, byte k of the tag sits in bits [8k+7:8k]
  localparam logic [31:0] TAG_RIFF_WORD = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE_WORD = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT_WORD  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA_WORD = 32'h6174_6164;

  typedef enum logic [1:0] {
    TAG_RIFF,
    TAG_WAVE,
    TAG_FMT,
    TAG_DATA
  } tag_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RIFF      = 3'd1,
    ERR_WAVE      = 3'd2,
    ERR_FMT_TAG   = 3'd3,
    ERR_FMT_LEN   = 3'd4,
    ERR_BYTE_RATE = 3'd5,
    ERR_ALIGN     = 3'd6,
    ERR_DATA_TAG  = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD_HI
  } mac_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_CB,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHECK
  } state_t;

  function automatic logic [7:0] tag_byte(input tag_t which, input logic [1:0] k);
    logic [31:0] word;
    begin
      unique case (which)
        TAG_RIFF: word = TAG_RIFF_WORD;
        TAG_WAVE: word = TAG_WAVE_WORD;
        TAG_FMT:  word = TAG_FMT_WORD;
        TAG_DATA: word = TAG_DATA_WORD;
        default:  word = TAG_RIFF_WORD;
      endcase
      tag_byte = word[{k, 3'b000} +: 8];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/whp_mac.sv @@
// shared 32x16 multiply-accumulate unit for the rate checks
// depends on whp_pkg
`default_nettype none

module whp_mac
  import whp_pkg::*;
(
  input  wire logic        clk,
  input  wire mac_cmd_t    cmd,
  input  wire logic [31:0] op_a,
  input  wire logic [15:0] op_b,
  output logic [63:0]      acc
);

  logic [47:0] prod;
  logic [63:0] acc_next;

  assign prod = op_a * op_b;

  always_comb begin
    unique case (cmd)
      MAC_LOAD:   acc_next = {16'b0, prod};
      // upper partial product lands 16 bits up
      MAC_ADD_HI: acc_next = acc + {prod, 16'b0};
      default:    acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

`default_nettype wire

@@ rtl/wav_header_parser_top.sv @@
// wav header parser top: byte capture, tag checks, check sequencer, result register
// depends on whp_pkg and whp_mac
//
// Input channel (in_valid/in_ready) takes one header byte per word with start_req
// marking byte 0 of a header; start_req also restarts a header already in progress.
// Output channel (out_valid/out_ready) gives one result word per complete 44-byte
// header: format, channels, sample rate, bits per sample, data length and the first
// error code (0 when the header is clean).
// After byte 35 (last byte of bits per sample) is taken, byte rate and block
// align are checked with one shared 32x16 multiplier over three products and
// a compare step, during which in_ready is low. The result word is valid in
// the cycle after byte 43 is taken.
// Bytes after the 44th are taken and dropped until the next start_req.
// Reset clears the byte position, the error code, the fields and out_valid.
// If the receiver stalls, the result stays in the output register and input bytes
// keep flowing; input waits only while the position sits at byte 43 or the checks run.
`default_nettype none

module wav_header_parser_top
  import whp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      audio_format,
  output logic [15:0]      channel_count,
  output logic [31:0]      sample_rate,
  output logic [15:0]      sample_bits,
  output logic [31:0]      data_length,
  output logic [2:0]       status
);

  state_t      state, state_next;
  logic [5:0]  byte_pos, byte_pos_next, pos_eff;
  logic [15:0] format_reg, format_next;
  logic [15:0] channels_reg, channels_next;
  logic [31:0] rate_reg, rate_next;
  logic [31:0] byte_rate_reg, byte_rate_next;
  logic [15:0] align_reg, align_next;
  logic [15:0] bits_reg, bits_next;
  logic [31:0] length_reg, length_next;
  err_t        first_error, first_error_next, err_base, byte_err;
  logic        accept, in_range, idle;

  mac_cmd_t    mac_cmd;
  logic [31:0] mac_a;
  logic [15:0] mac_b;
  logic [63:0] mac_acc;
  logic [31:0] cb_prod;
  logic        align_bad, rate_bad;

  whp_mac u_mac (
    .clk  (clk),
    .cmd  (mac_cmd),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  assign accept   = in_valid && in_ready;
  assign idle     = (state == ST_IDLE);
  assign in_ready = idle && (!out_valid || out_ready || (byte_pos != LAST_POS));
  assign pos_eff  = start_req ? 6'd0 : byte_pos;
  assign in_range = (pos_eff < HDR_BYTES);
  assign rate_bad = (mac_acc[63:35] != '0) || (mac_acc[34:3] != byte_rate_reg);

  // per-byte field capture and checks
  always_comb begin
    format_next    = format_reg;
    channels_next  = channels_reg;
    rate_next      = rate_reg;
    byte_rate_next = byte_rate_reg;
    align_next     = align_reg;
    bits_next      = bits_reg;
    length_next    = length_reg;
    byte_err       = ERR_NONE;
    if (pos_eff < 6'd4) begin
      if (data_byte != tag_byte(TAG_RIFF, pos_eff[1:0])) byte_err = ERR_RIFF;
    end else if (pos_eff < 6'd8) begin
      byte_err = ERR_NONE;
    end else if (pos_eff < 6'd12) begin
      if (data_byte != tag_byte(TAG_WAVE, pos_eff[1:0])) byte_err = ERR_WAVE;
    end else if (pos_eff < 6'd16) begin
      if (data_byte != tag_byte(TAG_FMT, pos_eff[1:0])) byte_err = ERR_FMT_TAG;
    end else if (pos_eff < 6'd20) begin
      if (data_byte != ((pos_eff == 6'd16) ? FMT_LEN_BYTE : 8'd0)) byte_err = ERR_FMT_LEN;
    end else if (pos_eff < 6'd22) begin
      format_next[{pos_eff[0], 3'b000} +: 8] = data_byte;
    end else if (pos_eff < 6'd24) begin
      channels_next[{pos_eff[0], 3'b000} +: 8] = data_byte;
    end else if (pos_eff < 6'd28) begin
      rate_next[{pos_eff[1:0], 3'b000} +: 8] = data_byte;
    end else if (pos_eff < 6'd32) begin
      byte_rate_next[{pos_eff[1:0], 3'b000} +: 8] = data_byte;
    end else if (pos_eff < 6'd34) begin
      align_next[{pos_eff[0], 3'b000} +: 8] = data_byte;
    end else if (pos_eff < 6'd36) begin
      bits_next[{pos_eff[0], 3'b000} +: 8] = data_byte;
    end else if (pos_eff < 6'd40) begin
      if (data_byte != tag_byte(TAG_DATA, pos_eff[1:0])) byte_err = ERR_DATA_TAG;
    end else if (in_range) begin
      length_next[{pos_eff[1:0], 3'b000} +: 8] = data_byte;
    end
  end

  always_comb begin
    err_base         = start_req ? ERR_NONE : first_error;
    first_error_next = err_base;
    if (in_range && (err_base == ERR_NONE)) first_error_next = byte_err;
    byte_pos_next    = in_range ? (pos_eff + 6'd1) : pos_eff;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && (pos_eff == CHECK_POS)) state_next = ST_MUL_CB;
      ST_MUL_CB: state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: operand selection for the shared unit
  always_comb begin
    mac_cmd = MAC_HOLD;
    mac_a   = cb_prod;
    mac_b   = rate_reg[31:16];
    unique case (state)
      ST_MUL_CB: begin
        mac_cmd = MAC_LOAD;
        mac_a   = {16'b0, channels_reg};
        mac_b   = bits_reg;
      end
      ST_MUL_LO: begin
        mac_cmd = MAC_LOAD;
        mac_a   = mac_acc[31:0];
        mac_b   = rate_reg[15:0];
      end
      ST_MUL_HI: begin
        mac_cmd = MAC_ADD_HI;
        mac_a   = cb_prod;
        mac_b   = rate_reg[31:16];
      end
      default: mac_cmd = MAC_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_pos      <= '0;
      first_error   <= ERR_NONE;
      format_reg    <= '0;
      channels_reg  <= '0;
      rate_reg      <= '0;
      byte_rate_reg <= '0;
      align_reg     <= '0;
      bits_reg      <= '0;
      length_reg    <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        byte_pos      <= byte_pos_next;
        first_error   <= first_error_next;
        format_reg    <= format_next;
        channels_reg  <= channels_next;
        rate_reg      <= rate_next;
        byte_rate_reg <= byte_rate_next;
        align_reg     <= align_next;
        bits_reg      <= bits_next;
        length_reg    <= length_next;
      end else if ((state == ST_CHECK) && (first_error == ERR_NONE)) begin
        // byte rate mismatch wins over block align
        if (rate_bad) first_error <= ERR_BYTE_RATE;
        else if (align_bad) first_error <= ERR_ALIGN;
      end
      if (accept && (pos_eff == LAST_POS)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // ch*bits held for the upper partial product, align check taken from it
  always_ff @(posedge clk) begin
    if (state == ST_MUL_LO) begin
      cb_prod   <= mac_acc[31:0];
      align_bad <= (mac_acc[31:3] != {13'b0, align_reg});
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos_eff == LAST_POS)) begin
      audio_format  <= format_next;
      channel_count <= channels_next;
      sample_rate   <= rate_next;
      sample_bits   <= bits_next;
      data_length   <= length_next;
      status        <= first_error_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/whp_checker.sv @@
// port-level checks for the wav header parser
// depends on wav_header_parser_top, attached by bind
`default_nettype none

module whp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        start_req,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] audio_format,
  input wire logic [15:0] channel_count,
  input wire logic [31:0] sample_rate,
  input wire logic [15:0] sample_bits,
  input wire logic [31:0] data_length,
  input wire logic [2:0]  status
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_length)
      && $stable(sample_rate) && $stable(audio_format) && $stable(channel_count)
      && $stable(sample_bits))
    else $error("result word changed while stalled");

  // a result only follows a taken byte
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without a taken byte");

  // a start byte never completes a header
  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req && !out_valid |=> !out_valid)
    else $error("start byte produced a result");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind wav_header_parser_top whp_checker u_whp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .start_req     (start_req),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .audio_format  (audio_format),
  .channel_count (channel_count),
  .sample_rate   (sample_rate),
  .sample_bits   (sample_bits),
  .data_length   (data_length),
  .status        (status)
);

`default_nettype wire

@@ tb/sv/tb_wav_header_parser_top.sv @@
// testbench for wav_header_parser_top: streams 44-byte wav headers through the byte channel
// and checks every result word against a byte-level header tracker; depends on whp_pkg
`timescale 1ns / 1ps

module tb_wav_header_parser_top
  import whp_pkg::*;
;

  localparam int HEADER_LEN   = 44;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  // ascii tags, first character in the top byte
  localparam logic [31:0] RIFF_TAG = "RIFF";
  localparam logic [31:0] WAVE_TAG = "WAVE";
  localparam logic [31:0] FMT_TAG  = "fmt ";
  localparam logic [31:0] DATA_TAG = "data";

  typedef logic [7:0] header_t [HEADER_LEN];

  typedef struct {
    logic [15:0] fmt;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] dlen;
    err_t        status;
  } hdr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        start_req = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] audio_format;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [31:0] data_length;
  logic [2:0]  status;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycle_count    = 0;

  class header_tracker;
    int          failures;
    hdr_result_t expected_headers [$];
    logic [5:0]  pos;
    logic [15:0] fmt, chans, align, bits;
    logic [31:0] rate, brate, dlen;
    err_t        first_err;

    function new();
      failures  = 0;
      pos       = '0;
      fmt       = '0;
      chans     = '0;
      align     = '0;
      bits      = '0;
      rate      = '0;
      brate     = '0;
      dlen      = '0;
      first_err = ERR_NONE;
    endfunction

    function void flag(err_t code);
      if (first_err == ERR_NONE) first_err = code;
    endfunction

    function void tag_check(logic [31:0] tag, int k, logic [7:0] b, err_t code);
      if (tag[31 - 8 * k -: 8] != b) flag(code);
    endfunction

    // 16 x 32 x 16 fits 64 bits exactly, so nothing is lost before the divide
    function void check_rates();
      logic [63:0] rate_product;
      logic [63:0] align_product;
      rate_product  = (64'(chans) * 64'(rate) * 64'(bits)) / 64'd8;
      align_product = (64'(chans) * 64'(bits)) / 64'd8;
      if (rate_product != 64'(brate)) flag(ERR_BYTE_RATE);
      else if (align_product != 64'(align)) flag(ERR_ALIGN);
    endfunction

    function void parse_byte(logic [7:0] b, logic s);
      int p;
      if (s) begin
        pos       = '0;
        first_err = ERR_NONE;
      end
      p = pos;
      if (p >= HEADER_LEN) return;
      if (p < 4) tag_check(RIFF_TAG, p, b, ERR_RIFF);
      else if (p < 8) begin
        // riff size is not checked
      end
      else if (p < 12) tag_check(WAVE_TAG, p - 8, b, ERR_WAVE);
      else if (p < 16) tag_check(FMT_TAG, p - 12, b, ERR_FMT_TAG);
      else if (p < 20) begin
        if (b != ((p == 16) ? 8'd16 : 8'd0)) flag(ERR_FMT_LEN);
      end
      else if (p < 22) fmt[(p - 20) * 8 +: 8] = b;
      else if (p < 24) chans[(p - 22) * 8 +: 8] = b;
      else if (p < 28) rate[(p - 24) * 8 +: 8] = b;
      else if (p < 32) brate[(p - 28) * 8 +: 8] = b;
      else if (p < 34) align[(p - 32) * 8 +: 8] = b;
      else if (p < 36) begin
        bits[(p - 34) * 8 +: 8] = b;
        if (p == 35) check_rates();
      end
      else if (p < 40) tag_check(DATA_TAG, p - 36, b, ERR_DATA_TAG);
      else dlen[(p - 40) * 8 +: 8] = b;
      pos = 6'(p + 1);
      if (pos == 6'(HEADER_LEN))
        expected_headers.push_back('{fmt, chans, rate, bits, dlen, first_err});
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t want;
      if (expected_headers.size() == 0) begin
        $error("result word with no complete header pending");
        failures++;
        return;
      end
      want = expected_headers.pop_front();
      compare_field("audio_format", want.fmt, got.fmt);
      compare_field("channel_count", want.chans, got.chans);
      compare_field("sample_rate", want.rate, got.rate);
      compare_field("sample_bits", want.bits, got.bits);
      compare_field("data_length", want.dlen, got.dlen);
      compare_field("status", want.status, got.status);
    endfunction

    function int pending_count();
      return expected_headers.size();
    endfunction
  endclass

  header_tracker tracker;

  wav_header_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_req     (start_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .audio_format  (audio_format),
    .channel_count (channel_count),
    .sample_rate   (sample_rate),
    .sample_bits   (sample_bits),
    .data_length   (data_length),
    .status        (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result(hdr_result_t'{audio_format, channel_count, sample_rate,
                                         sample_bits, data_length, err_t'(status)});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // block align and byte rate are made consistent here, so only overflow or a
  // later corruption makes the rate checks fail
  function automatic header_t build_header(input logic [15:0] fmt, chans,
                                           input logic [31:0] rate,
                                           input logic [15:0] bits,
                                           input logic [31:0] dlen);
    header_t     h;
    logic [63:0] byte_rate;
    logic [63:0] block_align;
    byte_rate   = (64'(chans) * 64'(rate) * 64'(bits)) / 64'd8;
    block_align = (64'(chans) * 64'(bits)) / 64'd8;
    for (int k = 0; k < 4; k++) begin
      h[k]      = RIFF_TAG[31 - 8 * k -: 8];
      h[4 + k]  = 8'($urandom);
      h[8 + k]  = WAVE_TAG[31 - 8 * k -: 8];
      h[12 + k] = FMT_TAG[31 - 8 * k -: 8];
      h[16 + k] = (k == 0) ? 8'd16 : 8'd0;
      h[24 + k] = rate[8 * k +: 8];
      h[28 + k] = byte_rate[8 * k +: 8];
      h[36 + k] = DATA_TAG[31 - 8 * k -: 8];
      h[40 + k] = dlen[8 * k +: 8];
    end
    for (int k = 0; k < 2; k++) begin
      h[20 + k] = fmt[8 * k +: 8];
      h[22 + k] = chans[8 * k +: 8];
      h[32 + k] = block_align[8 * k +: 8];
      h[34 + k] = bits[8 * k +: 8];
    end
    return h;
  endfunction

  function automatic header_t random_header();
    header_t     h;
    logic [31:0] common_rates [8] = '{8000, 11025, 16000, 22050, 44100, 48000, 96000, 192000};
    logic [15:0] fmt, chans, bits;
    logic [31:0] rate;
    fmt   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'd1;
    chans = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
    bits  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(8 * $urandom_range(1, 4));
    rate  = ($urandom_range(0, 7) == 0) ? $urandom : common_rates[$urandom_range(0, 7)];
    h = build_header(fmt, chans, rate, bits, $urandom);
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 2))
        h[$urandom_range(0, HEADER_LEN - 1)] ^= 8'($urandom_range(1, 255));
    end
    return h;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    start_req <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.parse_byte(b, s);
  endtask

  task automatic send_bytes(input header_t h, input int count, input logic with_start);
    for (int i = 0; i < count; i++) send_byte(h[i], with_start && (i == 0));
  endtask

  task automatic run_random(input int byte_budget);
    header_t h;
    int      counted;
    int      cut;
    int      n;
    counted = 0;
    while (counted < byte_budget) begin
      h = random_header();
      case ($urandom_range(0, 19))
        0, 1: begin
          // cut short, a later start byte restarts it
          cut = $urandom_range(1, HEADER_LEN - 1);
          send_bytes(h, cut, 1'b1);
          counted += cut;
        end
        2: begin
          send_bytes(h, HEADER_LEN, 1'b1);
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom), 1'b0);
          counted += HEADER_LEN + n;
        end
        3: begin
          n = $urandom_range(1, 10);
          repeat (n) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
          counted += n;
        end
        4: begin
          send_bytes(h, HEADER_LEN, 1'b0);
          counted += HEADER_LEN;
        end
        default: begin
          send_bytes(h, HEADER_LEN, 1'b1);
          counted += HEADER_LEN;
        end
      endcase
    end
  endtask

  initial begin
    header_t h;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first header straight after reset, no start flag
    h = build_header(16'd1, 16'd2, 32'd44100, 16'd16, 32'h0001_0000);
    send_bytes(h, HEADER_LEN, 1'b0);
    // clean header, then stray bytes that must be dropped
    h = build_header(16'd1, 16'd1, 32'd8000, 16'd8, 32'd0);
    send_bytes(h, HEADER_LEN, 1'b1);
    repeat (3) send_byte(8'hA5, 1'b0);
    h = build_header(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd0, 16'd0, 32'd0, 16'd0, 32'd0);
    send_bytes(h, HEADER_LEN, 1'b1);
    // at least one header per error kind
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[2] = 8'h00;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[11] = 8'h00;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[15] = 8'h00;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[16] = 8'd18;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[18] = 8'h01;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[28] ^= 8'h01;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[32] ^= 8'h01;
    send_bytes(h, HEADER_LEN, 1'b1);
    h = build_header(16'd1, 16'd2, 32'd48000, 16'd24, 32'd1000);
    h[39] = 8'h00;
    send_bytes(h, HEADER_LEN, 1'b1);
    // two faults, only the earlier one is reported
    h = build_header(16'd3, 16'd6, 32'd96000, 16'd32, 32'h8000_0000);
    h[0]  = 8'h00;
    h[37] = 8'h00;
    send_bytes(h, HEADER_LEN, 1'b1);
    // restart in mid header
    h = build_header(16'd1, 16'd2, 32'd22050, 16'd16, 32'd77);
    send_bytes(h, 20, 1'b1);
    send_bytes(h, HEADER_LEN, 1'b1);

    run_random(350);
    src_idle_pct = 86;
    run_random(350);
    src_idle_pct   = 0;
    sink_stall_pct = 86;
    run_random(350);
    src_idle_pct   = 22;
    sink_stall_pct = 22;
    run_random(350);
    in_valid <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
